// ===== hw/rtl/lpcd_pkg.sv =====
// Shared types, constants and helpers for the LRU page cache directory.
// No dependencies; imported by lru_page_cache_directory_core.
package lpcd_pkg;

  // Directory size and stored key width
  localparam int MAX_ENTRIES  = 16;
  localparam int FILE_ID_BITS = 8;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Fixed field widths
  localparam int CAP_W     = 5;
  localparam int KIND_W    = 2;
  localparam int FID_W     = 8;
  localparam int PID_W     = 32;
  localparam int SLOT_W    = 4;
  localparam int CTR_W     = 32;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 144;

  // Operation codes (input kind)
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t OP_GET   = 2'd0;
  localparam kind_t OP_PUT   = 2'd1;
  localparam kind_t OP_FLUSH = 2'd2;

  // Result kinds
  localparam kind_t RK_ACCESS = 2'd0;
  localparam kind_t RK_WB     = 2'd1;
  localparam kind_t RK_DONE   = 2'd2;

  // Configuration register indexes
  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_CAP     = 1'b0;
  localparam cfg_idx_t CFG_BACKING = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_COMMIT,
    ST_OUT_WB,
    ST_OUT_LAST,
    ST_FL_SCAN,
    ST_FL_OUT
  } st_e;

  // Outcome of one lookup, held for the commit cycle
  typedef struct packed {
    logic             hit;
    logic             evict;
    logic             wb;
    logic [IDX_W-1:0] slot;
  } look_t;

  // Lowest set bit of an entry vector
  function automatic logic [IDX_W-1:0] lowest_idx(input logic [MAX_ENTRIES-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/lru_page_cache_directory_core.sv =====
// Fully associative LRU page cache directory, top level.
// Depends on lpcd_pkg (types, constants, priority encoder).

// Tracks up to MAX_ENTRIES (file, page) pairs with valid/dirty marks and an
// LRU rank per entry (0 = most recent). Ready is high only while idle; one
// word is in flight at a time. A get or put passes through a lookup state
// (all entries compared at once by the comparator bank) and a commit state,
// then its result words leave one per cycle that the sink takes: a writeback
// word first if a dirty eviction emits one, then the access word, and the
// block returns to idle once the last word is taken. A flush walks the ranks
// 0..MAX_ENTRIES-1 with the same comparator bank, one rank per cycle except
// where it emits a writeback word for a dirty entry and rescans that rank,
// then emits flush done. Kind 3 is accepted and dropped. Counter fields on
// every word are the totals after the whole input. Valid entries always hold
// ranks 0..occupancy-1, so the LRU victim is the valid entry whose rank
// equals occupancy-1. Config writes take effect on the next edge and are
// expected only while idle.
module lru_page_cache_directory_core
  import lpcd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input words
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // file_id[7:0], page_id[39:8]
  input  logic [KIND_W-1:0]    s_axis_tuser,  // kind[1:0]
  // result words
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // hit[0], fill_needed[1], slot[5:2], out_file_id[13:6], out_page_id[45:14],
  // hit_total[77:46], miss_total[109:78], eviction_total[141:110], zero[143:142]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic [KIND_W-1:0]    m_axis_tuser,  // result_kind[1:0]
  output logic                 m_axis_tlast,
  // config writes
  input  logic                 cfg_we_i,
  input  cfg_idx_t             cfg_idx_i,
  input  logic [CAP_W-1:0]     cfg_data_i
);

  st_e state_q, state_d;

  // config
  logic [CAP_W-1:0] cap_q;
  logic             backing_q;

  // directory
  logic [FILE_ID_BITS-1:0] file_q [MAX_ENTRIES];
  logic [FILE_ID_BITS-1:0] file_d [MAX_ENTRIES];
  logic [PID_W-1:0]        page_q [MAX_ENTRIES];
  logic [PID_W-1:0]        page_d [MAX_ENTRIES];
  logic [IDX_W-1:0]        rank_q [MAX_ENTRIES];
  logic [IDX_W-1:0]        rank_d [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  valid_q, valid_d;
  logic [MAX_ENTRIES-1:0]  dirty_q, dirty_d;
  logic [CNT_W-1:0]        occ_q, occ_d;

  // stats
  logic [CTR_W-1:0] hits_q, hits_d;
  logic [CTR_W-1:0] misses_q, misses_d;
  logic [CTR_W-1:0] evicts_q, evicts_d;

  // current request
  logic                    req_put_q;
  logic [FILE_ID_BITS-1:0] req_fid_q;
  logic [PID_W-1:0]        req_pid_q;
  look_t                   look_q, look_d;
  logic [IDX_W-1:0]        scan_q, scan_d;

  // output word
  kind_t                   out_kind_q, out_kind_d;
  logic                    out_hit_q, out_hit_d;
  logic                    out_fill_q, out_fill_d;
  logic [IDX_W-1:0]        out_slot_q, out_slot_d;
  logic [FILE_ID_BITS-1:0] out_fid_q, out_fid_d;
  logic [PID_W-1:0]        out_pid_q, out_pid_d;
  logic                    out_last_q, out_last_d;

  logic                    accept;
  kind_t                   in_kind;
  logic [FILE_ID_BITS-1:0] in_fid;
  logic [PID_W-1:0]        in_pid;

  // comparator bank
  logic [MAX_ENTRIES-1:0] match_vec, victim_vec, flush_vec;
  logic [CNT_W-1:0]       occ_m1;
  logic [CAP_W-1:0]       cap_eff;
  logic                   full;
  logic [IDX_W-1:0]       victim_idx, flush_idx;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign in_kind = s_axis_tuser;
  assign in_fid  = FILE_ID_BITS'(s_axis_tdata[7:0]);
  assign in_pid  = s_axis_tdata[39:8];

  assign occ_m1 = occ_q - CNT_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_vec[i]  = valid_q[i] && (file_q[i] == req_fid_q) && (page_q[i] == req_pid_q);
      victim_vec[i] = valid_q[i] && (rank_q[i] == occ_m1[IDX_W-1:0]);
      flush_vec[i]  = valid_q[i] && dirty_q[i] && backing_q && (rank_q[i] == scan_q);
    end
  end

  // capacity clamped to 1..MAX_ENTRIES
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_q > CAP_W'(MAX_ENTRIES)) begin
      cap_eff = CAP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign full       = CAP_W'(occ_q) >= cap_eff;
  assign victim_idx = lowest_idx(victim_vec);
  assign flush_idx  = lowest_idx(flush_vec);

  // lookup outcome
  always_comb begin
    look_d.hit   = |match_vec;
    look_d.evict = !look_d.hit && full;
    look_d.wb    = look_d.evict && dirty_q[victim_idx] && backing_q;
    if (look_d.hit) begin
      look_d.slot = lowest_idx(match_vec);
    end else if (look_d.evict) begin
      look_d.slot = victim_idx;
    end else begin
      look_d.slot = lowest_idx(~valid_q);
    end
  end

  // directory and counter update
  always_comb begin
    logic [IDX_W-1:0] hit_rank;
    hit_rank = rank_q[look_q.slot];
    file_d   = file_q;
    page_d   = page_q;
    rank_d   = rank_q;
    valid_d  = valid_q;
    dirty_d  = dirty_q;
    occ_d    = occ_q;
    hits_d   = hits_q;
    misses_d = misses_q;
    evicts_d = evicts_q;
    case (state_q)
      ST_COMMIT: begin
        if (look_q.hit) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (valid_q[i] && (IDX_W'(i) != look_q.slot) && (rank_q[i] < hit_rank)) begin
              rank_d[i] = rank_q[i] + IDX_W'(1);
            end
          end
          rank_d[look_q.slot] = '0;
          if (req_put_q) begin
            dirty_d[look_q.slot] = 1'b1;
          end else begin
            hits_d = hits_q + CTR_W'(1);
          end
        end else begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (valid_q[i] && (IDX_W'(i) != look_q.slot)) begin
              rank_d[i] = rank_q[i] + IDX_W'(1);
            end
          end
          valid_d[look_q.slot] = 1'b1;
          dirty_d[look_q.slot] = req_put_q;
          file_d[look_q.slot]  = req_fid_q;
          page_d[look_q.slot]  = req_pid_q;
          rank_d[look_q.slot]  = '0;
          if (!req_put_q) misses_d = misses_q + CTR_W'(1);
          if (look_q.evict) begin
            evicts_d = evicts_q + CTR_W'(1);
          end else begin
            occ_d = occ_q + CNT_W'(1);
          end
        end
      end
      ST_FL_SCAN: begin
        if (|flush_vec) dirty_d[flush_idx] = 1'b0;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            OP_GET, OP_PUT: state_d = ST_LOOK;
            OP_FLUSH:       state_d = ST_FL_SCAN;
            default:        state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOK:     state_d = ST_COMMIT;
      ST_COMMIT:   state_d = look_q.wb ? ST_OUT_WB : ST_OUT_LAST;
      ST_OUT_WB:   if (m_axis_tready) state_d = ST_OUT_LAST;
      ST_OUT_LAST: if (m_axis_tready) state_d = ST_IDLE;
      ST_FL_SCAN: begin
        if (|flush_vec) begin
          state_d = ST_FL_OUT;
        end else if (scan_q == IDX_W'(MAX_ENTRIES - 1)) begin
          state_d = ST_OUT_LAST;
        end
      end
      ST_FL_OUT:   if (m_axis_tready) state_d = ST_FL_SCAN;
      default:     state_d = ST_IDLE;
    endcase
  end

  // output word and scan counter
  always_comb begin
    scan_d     = scan_q;
    out_kind_d = out_kind_q;
    out_hit_d  = out_hit_q;
    out_fill_d = out_fill_q;
    out_slot_d = out_slot_q;
    out_fid_d  = out_fid_q;
    out_pid_d  = out_pid_q;
    out_last_d = out_last_q;
    case (state_q)
      ST_IDLE: scan_d = '0;
      ST_COMMIT, ST_OUT_WB: begin
        if ((state_q == ST_COMMIT) && look_q.wb) begin
          // victim still holds its old key this cycle
          out_kind_d = RK_WB;
          out_hit_d  = 1'b0;
          out_fill_d = 1'b0;
          out_slot_d = look_q.slot;
          out_fid_d  = file_q[look_q.slot];
          out_pid_d  = page_q[look_q.slot];
          out_last_d = 1'b0;
        end else if ((state_q == ST_COMMIT) || m_axis_tready) begin
          out_kind_d = RK_ACCESS;
          out_hit_d  = look_q.hit;
          out_fill_d = !look_q.hit && !req_put_q && backing_q;
          out_slot_d = look_q.slot;
          out_fid_d  = req_fid_q;
          out_pid_d  = req_pid_q;
          out_last_d = 1'b1;
        end
      end
      ST_FL_SCAN: begin
        if (|flush_vec) begin
          // the scan stays on this rank and rescans it after the word is taken
          out_kind_d = RK_WB;
          out_hit_d  = 1'b0;
          out_fill_d = 1'b0;
          out_slot_d = flush_idx;
          out_fid_d  = file_q[flush_idx];
          out_pid_d  = page_q[flush_idx];
          out_last_d = 1'b0;
        end else if (scan_q == IDX_W'(MAX_ENTRIES - 1)) begin
          out_kind_d = RK_DONE;
          out_hit_d  = 1'b0;
          out_fill_d = 1'b0;
          out_slot_d = '0;
          out_fid_d  = '0;
          out_pid_d  = '0;
          out_last_d = 1'b1;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cap_q     <= CAP_W'(16);
      backing_q <= 1'b1;
      valid_q   <= '0;
      dirty_q   <= '0;
      occ_q     <= '0;
      hits_q    <= '0;
      misses_q  <= '0;
      evicts_q  <= '0;
      scan_q    <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) rank_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      dirty_q  <= dirty_d;
      occ_q    <= occ_d;
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
      scan_q   <= scan_d;
      rank_q   <= rank_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CAP:     cap_q     <= cfg_data_i;
          CFG_BACKING: backing_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    file_q     <= file_d;
    page_q     <= page_d;
    out_kind_q <= out_kind_d;
    out_hit_q  <= out_hit_d;
    out_fill_q <= out_fill_d;
    out_slot_q <= out_slot_d;
    out_fid_q  <= out_fid_d;
    out_pid_q  <= out_pid_d;
    out_last_q <= out_last_d;
    if (accept) begin
      req_put_q <= (in_kind == OP_PUT);
      req_fid_q <= in_fid;
      req_pid_q <= in_pid;
    end
    if (state_q == ST_LOOK) look_q <= look_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT_WB) || (state_q == ST_OUT_LAST) ||
                         (state_q == ST_FL_OUT);
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, evicts_q, misses_q, hits_q, out_pid_q,
                          FID_W'(out_fid_q), SLOT_W'(out_slot_q), out_fill_q, out_hit_q};

  // one item at a time: no result word is offered while taking input
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a result word is pending");

  // occupancy counter tracks the valid marks
  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == CNT_W'($countones(valid_q)))
    else $error("occupancy count out of step with valid marks");

  // a taken writeback of an access is followed by its access word
  a_wb_then_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT_WB) && m_axis_tready |=>
      m_axis_tvalid && m_axis_tlast && (m_axis_tuser == RK_ACCESS))
    else $error("access word missing after eviction writeback");

  // counters move only in the commit cycle
  a_ctr_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_COMMIT) |=> $stable(hits_q) && $stable(misses_q) && $stable(evicts_q))
    else $error("statistics counter changed outside commit");

endmodule
